[rtl/tks_pkg.sv]
// Shared constants and types for the top-K score selector.
package tks_pkg;

  localparam int VECTOR_LEN = 768;
  localparam int TOP_K      = 5;

  localparam int SCORE_W   = 32;
  localparam int IDX_W     = $clog2(VECTOR_LEN);
  localparam int CNT_W     = $clog2(VECTOR_LEN + 1);
  localparam int COL_W     = 8;
  localparam int END_W     = COL_W + 1;
  localparam int DIV_CNT_W = $clog2(IDX_W);

  localparam int OUT_DATA_W = 72;

  localparam logic [COL_W-1:0] COLS_RESET = 8'd80;
  localparam logic [COL_W-1:0] SPAN_RESET = 8'd10;

  // Register indexes on the configuration port (taken from paddr[2]).
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_SPAN    = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [SCORE_W-1:0] score;
    logic [IDX_W-1:0]   index;
  } tks_entry_t;

  typedef struct packed {
    logic ins;    // rank the new element into the chain
    logic clear;  // drop every kept entry
    logic drain;  // move every entry one place toward the head
  } tks_cell_ctrl_t;

endpackage

[rtl/tks_cell.sv]
// One ranking cell: holds a kept entry and passes it along the chain.
module tks_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tks_pkg::tks_cell_ctrl_t      ctrl,
  input  logic [tks_pkg::SCORE_W-1:0]  new_score,
  input  logic [tks_pkg::IDX_W-1:0]    new_index,
  input  tks_pkg::tks_entry_t          prev_entry,
  input  logic                         prev_above,
  input  tks_pkg::tks_entry_t          next_entry,
  output tks_pkg::tks_entry_t          entry,
  output logic                         above
);
  import tks_pkg::*;

  tks_entry_t ent_r;
  tks_entry_t ent_nxt;

  // The new element goes above this entry when the slot is empty or the kept
  // score is lower or equal (the new index is always the later one).
  assign above = !ent_r.valid || ($signed(ent_r.score) <= $signed(new_score));
  assign entry = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.clear) begin
      ent_nxt.valid = 1'b0;
    end else if (ctrl.ins) begin
      if (prev_above) begin
        ent_nxt = prev_entry;
      end else if (above) begin
        ent_nxt.valid = 1'b1;
        ent_nxt.score = new_score;
        ent_nxt.index = new_index;
      end
    end else if (ctrl.drain) begin
      ent_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
      ent_r.score <= '0;
      ent_r.index <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

[rtl/tks_div.sv]
// Restoring divider that splits an element index into line and column.
module tks_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tks_pkg::IDX_W-1:0] dividend,
  input  logic [tks_pkg::COL_W-1:0] divisor,
  output logic                      done,
  output logic [tks_pkg::IDX_W-1:0] quotient,
  output logic [tks_pkg::COL_W-1:0] remainder
);
  import tks_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0]     quo_r;
  logic [IDX_W-1:0]     quo_nxt;
  logic [COL_W-1:0]     rem_r;
  logic [COL_W-1:0]     rem_nxt;
  logic [COL_W-1:0]     div_r;
  logic [COL_W:0]       shifted;

  // One quotient bit per cycle. The remainder stays below the divisor, so the
  // shifted value fits one bit wider than a column.
  always_comb begin
    shifted = {rem_r, quo_r[IDX_W-1]};
    if (shifted >= {1'b0, div_r}) begin
      rem_nxt = COL_W'(shifted - {1'b0, div_r});
      quo_nxt = {quo_r[IDX_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[COL_W-1:0];
      quo_nxt = {quo_r[IDX_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        // A divisor of zero is treated as one.
        div_r  <= (divisor == '0) ? COL_W'(1) : divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(IDX_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[rtl/top_k_score_selector.sv]
// Top level: keeps the five largest scores of a vector and reports them.
// Ranking takes one element per cycle; in_tready stays high while ranking.
// The first result follows the vector's last element through a load state,
// the shared restoring divider and the output register; each further result
// passes the same steps after the handover, plus any wait for out_tready;
// no element is taken until all results are out.
// Synchronous active-low reset empties every slot, zeroes the element count
// and sets columns_per_line to 80 and highlight_span to 10.
module top_k_score_selector (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: score[31:0]; in_tlast: vector_end
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,
  input  logic                           in_tlast,
  // out_tdata: element_index[9:0], line_number[19:10], start_column[27:20],
  // end_column[36:28], confidence[68:37], zero[71:69]; out_tlast: last_of_run
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tks_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [2:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import tks_pkg::*;

  typedef enum logic [1:0] {
    S_RANK,
    S_LOAD,
    S_DIV,
    S_OUT
  } state_t;

  state_t           state_r;
  logic [COL_W-1:0] cols_r;
  logic [COL_W-1:0] span_r;
  logic [CNT_W-1:0] count_r;

  logic             in_acc;
  logic             full;
  tks_cell_ctrl_t   ctrl;

  tks_entry_t       ent [TOP_K];
  logic             above [TOP_K];

  logic             div_done;
  logic [IDX_W-1:0] div_quo;
  logic [COL_W-1:0] div_rem;

  logic [IDX_W-1:0]   o_index_r;
  logic [IDX_W-1:0]   o_line_r;
  logic [COL_W-1:0]   o_start_r;
  logic [END_W-1:0]   o_end_r;
  logic [SCORE_W-1:0] o_conf_r;
  logic               o_last_r;
  logic               o_valid_r;
  logic               second_valid;

  // Configuration port.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
      span_r <= SPAN_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[2])
        REG_COLUMNS: cols_r <= cfg_pwdata[COL_W-1:0];
        REG_SPAN:    span_r <= cfg_pwdata[COL_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_COLUMNS: cfg_prdata = {{(32-COL_W){1'b0}}, cols_r};
      REG_SPAN:    cfg_prdata = {{(32-COL_W){1'b0}}, span_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // Element intake and chain control.
  assign in_tready = (state_r == S_RANK);
  assign in_acc    = in_tvalid && in_tready;
  // The vector is complete if the count reaches the limit with this element.
  assign full = (count_r == CNT_W'(VECTOR_LEN)) || (count_r == CNT_W'(VECTOR_LEN - 1));

  assign ctrl.ins   = in_acc && (count_r < CNT_W'(VECTOR_LEN));
  assign ctrl.clear = in_acc && in_tlast && !full;
  assign ctrl.drain = (state_r == S_OUT) && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_acc) begin
      if (in_tlast) begin
        count_r <= '0;
      end else if (count_r < CNT_W'(VECTOR_LEN)) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  for (genvar i = 0; i < TOP_K; i++) begin : g_cell
    tks_entry_t prev_e;
    tks_entry_t next_e;
    logic       prev_a;

    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_a = 1'b0;
    end else begin : g_body
      assign prev_e = ent[i-1];
      assign prev_a = above[i-1];
    end

    if (i == TOP_K - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = ent[i+1];
    end

    tks_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_score  (in_tdata),
      .new_index  (count_r[IDX_W-1:0]),
      .prev_entry (prev_e),
      .prev_above (prev_a),
      .next_entry (next_e),
      .entry      (ent[i]),
      .above      (above[i])
    );
  end

  if (TOP_K > 1) begin : g_second
    assign second_valid = ent[1].valid;
  end else begin : g_single
    assign second_valid = 1'b0;
  end

  tks_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == S_LOAD),
    .dividend  (ent[0].index),
    .divisor   (cols_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Result sequencer: the head cell is reported, then the chain moves up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_RANK;
      o_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_RANK: begin
          if (in_acc && in_tlast && full) begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            o_index_r <= ent[0].index;
            o_line_r  <= div_quo;
            o_start_r <= div_rem;
            o_end_r   <= {1'b0, div_rem} + {1'b0, span_r};
            o_conf_r  <= ent[0].score;
            o_last_r  <= !second_valid;
            o_valid_r <= 1'b1;
            state_r   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            o_valid_r <= 1'b0;
            state_r   <= second_valid ? S_LOAD : S_RANK;
          end
        end
        default: begin
          state_r   <= S_RANK;
          o_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {{(OUT_DATA_W - 2*IDX_W - COL_W - END_W - SCORE_W){1'b0}},
                       o_conf_r, o_end_r, o_start_r, o_line_r, o_index_r};

endmodule
